/* rtl/core/vtp_pkg.sv */
// shared types and constants for the vertex transform with perspective divide
package vtp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 8;
  localparam int SUM_W         = 66;
  localparam int MAG_W         = 64;
  localparam int QBITS         = 33;
  localparam int IN_DATA_W     = 136;
  localparam int OUT_DATA_W    = 96;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } row_t;

  typedef struct packed {
    row_t w;
    row_t z;
    row_t y;
    row_t x;
  } sums_t;

  typedef struct packed {
    logic v3;
    logic v2;
    logic v1;
  } front_stat_t;

endpackage

/* rtl/core/vtp_front.sv */
// front end: coefficient store, row products, row sums and magnitudes
module vtp_front import vtp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  op_t                op,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output front_stat_t        stat,
  output logic               push,
  output sums_t              push_data
);

  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  logic signed [31:0]      coef [0:15];
  logic signed [63:0]      prod [0:3][0:2];
  logic signed [SUM_W-1:0] bias [0:3];
  logic signed [SUM_W-1:0] sum  [0:3];
  logic signed [31:0]      pt   [0:2];
  logic                    v1, v2, v3;
  row_t                    rows [0:3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        coef[i] <= (i % 5 == 0) ? ONE : 32'd0;
      end
    end else if (accept && op == OP_LOAD) begin
      coef[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept && op == OP_XFORM;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod[r][j] <= 64'(coef[r*4+j]) * 64'(pt[j]);
      end
      bias[r] <= SUM_W'(coef[r*4+3]) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      sum[r] <= bias[r] + SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      rows[r].neg <= sum[r][SUM_W-1];
      rows[r].mag <= sum[r][SUM_W-1] ? MAG_W'(-sum[r]) : MAG_W'(sum[r]);
    end
  end

  assign stat      = '{v3: v3, v2: v2, v1: v1};
  assign push      = v3;
  assign push_data = '{w: rows[3], z: rows[2], y: rows[1], x: rows[0]};

endmodule

/* rtl/core/vtp_queue.sv */
// short queue of row sums between front and back
module vtp_queue import vtp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  sums_t                    push_data,
  input  logic                     pop,
  output logic                     not_empty,
  output sums_t                    head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sums_t         mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + {{($bits(count)-1){1'b0}}, push} - {{($bits(count)-1){1'b0}}, pop};
    end
  end

  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

endmodule

/* rtl/core/vtp_divider.sv */
// pipelined restoring divider for one projected coordinate, with saturation
module vtp_divider import vtp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  row_t             num,
  input  row_t             den,
  output logic [31:0]      result,
  output logic             sat
);

  localparam int NW = MAG_W + FRAC_BITS;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QBITS-1:0] lo;
    logic [QBITS-1:0] q;
    logic [MAG_W-1:0] d;
    logic             neg;
    logic             sat;
  } div_t;

  div_t          st [0:QBITS];
  logic [NW-1:0] numer, hi;
  div_t          init;
  logic [QBITS-1:0] limit, q_neg;

  always_comb begin
    numer     = {num.mag, {FRAC_BITS{1'b0}}};
    hi        = numer >> QBITS;
    init.rem  = hi[MAG_W-1:0];
    init.lo   = numer[QBITS-1:0];
    init.q    = '0;
    init.d    = den.mag;
    init.neg  = num.neg ^ den.neg;
    init.sat  = hi >= NW'(den.mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= init;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [MAG_W:0] r2, diff;
    logic           ge;
    div_t           nxt;

    always_comb begin
      r2       = {st[k].rem, st[k].lo[QBITS-1]};
      diff     = r2 - {1'b0, st[k].d};
      ge       = r2 >= {1'b0, st[k].d};
      nxt      = st[k];
      nxt.rem  = ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
      nxt.lo   = {st[k].lo[QBITS-2:0], 1'b0};
      nxt.q    = {st[k].q[QBITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    limit  = st[QBITS].neg ? 33'h080000000 : 33'h07fffffff;
    q_neg  = 33'd0 - st[QBITS].q;
    sat    = st[QBITS].sat || st[QBITS].q > limit;
    result = sat ? limit[31:0] : (st[QBITS].neg ? q_neg[31:0] : st[QBITS].q[31:0]);
  end

endmodule

/* rtl/core/vtp_back.sv */
// back end: three dividers, zero-w handling and output register
module vtp_back import vtp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  sums_t                 head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser
);

  logic              en;
  logic [QBITS:0]    vld;
  logic [QBITS:0]    wz;
  logic [31:0]       res [0:2];
  logic [2:0]        sat;
  row_t              nums [0:2];

  assign en  = !m_tvalid || m_tready;
  assign pop = not_empty && en;

  assign nums[0] = head.x;
  assign nums[1] = head.y;
  assign nums[2] = head.z;

  for (genvar c = 0; c < 3; c++) begin : g_div
    vtp_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk    (clk),
      .en     (en),
      .num    (nums[c]),
      .den    (head.w),
      .result (res[c]),
      .sat    (sat[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[QBITS-1:0], pop};
      m_tvalid <= vld[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz <= {wz[QBITS-1:0], head.w.mag == '0};
      if (wz[QBITS]) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {res[2], res[1], res[0]};
        m_tuser <= {|sat, 1'b0};
      end
    end
  end

endmodule

/* rtl/core/vertex_transform_perspective_divide.sv */
// top level of the 4x4 point transform with perspective divide
// Takes one item per clock while s_tready is high, which holds until queued and
// in-flight transform items fill the queue. A load item writes one matrix
// coefficient in the cycle it is accepted and gives no result; a transform item
// gives one result through the three-stage product and sum front end, the queue
// and the 33-step restoring divider pipeline plus output register in the back
// end. The matrix resets to identity. A queue of eight row-sum entries sits
// between front and back so input transfers continue while the output stalls.
module vertex_transform_perspective_divide import vtp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // coef_index, coef_value, point_x, point_y, point_z, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x, out_y, out_z
  output logic [OUT_DATA_W-1:0] m_tdata,
  // w_zero, saturated
  output logic [1:0]            m_tuser
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept, push, pop, not_empty;
  sums_t         push_data, head;
  front_stat_t   stat;
  logic [CW-1:0] count;
  logic [CW:0]   occ;

  assign occ      = (CW+1)'(count) + (CW+1)'(stat.v1) + (CW+1)'(stat.v2) + (CW+1)'(stat.v3);
  assign s_tready = occ < (CW+1)'(QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;

  vtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op_t'(s_tuser[0])),
    .coef_index (s_tdata[3:0]),
    .coef_value (s_tdata[35:4]),
    .point_x    (s_tdata[67:36]),
    .point_y    (s_tdata[99:68]),
    .point_z    (s_tdata[131:100]),
    .stat       (stat),
    .push       (push),
    .push_data  (push_data)
  );

  vtp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .count     (count)
  );

  vtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= (CW+1)'(QUEUE_DEPTH))
    else $error("queue credit exceeded");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> count < CW'(QUEUE_DEPTH))
    else $error("push into full queue");

  a_wzero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("zero w result not cleared");

endmodule

/* tb/sv/vertex_transform_perspective_divide_checker.sv */
// checker: predicts projected points from observed transfers and compares results
module vertex_transform_perspective_divide_checker import vtp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [1:0]            m_tuser,
  output int                    fail_count,
  output int                    pending,
  output int                    n_points,
  output int                    n_wzero,
  output int                    n_clamped
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } proj_t;

  logic [31:0] coef [16];
  proj_t       proj_q [$];

  assign pending = proj_q.size();

  function automatic logic signed [127:0] row_total(input int r, input logic [31:0] px,
                                                    input logic [31:0] py,
                                                    input logic [31:0] pz);
    logic signed [127:0] acc;
    logic signed [127:0] c;
    logic signed [127:0] p;
    c = $signed(coef[r*4+3]);
    acc = c <<< FRAC_BITS;
    c = $signed(coef[r*4]);   p = $signed(px); acc = acc + c * p;
    c = $signed(coef[r*4+1]); p = $signed(py); acc = acc + c * p;
    c = $signed(coef[r*4+2]); p = $signed(pz); acc = acc + c * p;
    return acc;
  endfunction

  function automatic logic [31:0] divide_row(input logic signed [127:0] num,
                                             input logic signed [127:0] den,
                                             inout logic sat);
    logic [127:0] nm;
    logic [127:0] dm;
    logic [127:0] q;
    logic [127:0] lim;
    logic         neg;
    neg = num[127] ^ den[127];
    nm  = num[127] ? -num : num;
    dm  = den[127] ? -den : den;
    q   = (nm << FRAC_BITS) / dm;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      return lim[31:0];
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic proj_t project_point(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz);
    proj_t               r;
    logic signed [127:0] w;
    logic                sat;
    sat = 1'b0;
    r = '0;
    w = row_total(3, px, py, pz);
    if (w == 0) begin
      r.wz = 1'b1;
      return r;
    end
    r.x = divide_row(row_total(0, px, py, pz), w, sat);
    r.y = divide_row(row_total(1, px, py, pz), w, sat);
    r.z = divide_row(row_total(2, px, py, pz), w, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    proj_t e;
    if (rst) begin
      for (int i = 0; i < 16; i++) coef[i] = (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
      proj_q.delete();
      n_points = 0;
      n_wzero = 0;
      n_clamped = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (op_t'(s_tuser[0]) == OP_LOAD) begin
          coef[s_tdata[3:0]] = s_tdata[35:4];
        end else begin
          e = project_point(s_tdata[67:36], s_tdata[99:68], s_tdata[131:100]);
          proj_q.push_back(e);
          n_points++;
          if (e.wz) n_wzero++;
          if (e.sat) n_clamped++;
        end
      end
      if (m_tvalid && m_tready) begin
        if (proj_q.size() == 0) begin
          report("unexpected result", m_tdata[31:0], 32'd0);
        end else begin
          e = proj_q.pop_front();
          if (m_tdata[31:0] !== e.x) report("out_x", m_tdata[31:0], e.x);
          if (m_tdata[63:32] !== e.y) report("out_y", m_tdata[63:32], e.y);
          if (m_tdata[95:64] !== e.z) report("out_z", m_tdata[95:64], e.z);
          if (m_tuser[0] !== e.wz) report("w_zero", 32'(m_tuser[0]), 32'(e.wz));
          if (m_tuser[1] !== e.sat) report("saturated", 32'(m_tuser[1]), 32'(e.sat));
        end
      end
    end
  end

endmodule

/* tb/sv/vertex_transform_perspective_divide_tb.sv */
// testbench top: drives loads and points with random gaps and reports the verdict
module vertex_transform_perspective_divide_tb import vtp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  int fail_count, pending, n_points, n_wzero, n_clamped;
  int n_items = 0;
  int out_hold = 0;
  bit quiet = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vertex_transform_perspective_divide u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  vertex_transform_perspective_divide_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending), .n_points(n_points),
    .n_wzero(n_wzero), .n_clamped(n_clamped)
  );

  function automatic int gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // output side back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      m_tready <= 1'b0;
      out_hold--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      out_hold = gap_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send(input op_t op, input logic [3:0] idx, input logic [31:0] val,
                      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'd0, pz, py, px, val, idx};
    do @(posedge clk); while (!s_tready);
    n_items++;
    @(negedge clk);
  endtask

  task automatic load(input logic [3:0] idx, input logic [31:0] val);
    send(OP_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic xform(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
    send(OP_XFORM, 4'($urandom), $urandom, px, py, pz);
  endtask

  function automatic logic [31:0] small_val(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] coef_val();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 32'd0;
      2:       return 32'h0001_0000;
      default: return small_val(32'h0004_0000);
    endcase
  endfunction

  function automatic logic [31:0] point_val();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return small_val(32'h0100_0000);
    endcase
  endfunction

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("vertex_transform_perspective_divide verification failed");
    $finish;
  end

  initial begin
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // identity matrix after reset
    xform(32'h0001_0000, 32'hFFFE_0000, 32'h0003_8000);
    xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    xform(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // negative w
    load(4'd15, 32'h8000_0000);
    xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    // overflow clamps
    load(4'd15, 32'h0000_0001);
    load(4'd0, 32'h7FFF_FFFF);
    xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    xform(32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    // w exactly zero
    load(4'd15, 32'h0000_0000);
    xform(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
    // w from x term only, zero point gives zero w
    load(4'd12, 32'hFFFF_0000);
    load(4'd3, 32'h7FFF_FFFF);
    xform(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    xform(32'h0002_0000, 32'h0004_0000, 32'hFFF8_0000);
    // back to identity
    for (int i = 0; i < 16; i++) load(i[3:0], (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
    xform(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);

    k = 0;
    while (n_items < 1200) begin
      k++;
      quiet = (k > 400 && k < 550);
      case ($urandom_range(0, 19))
        0: for (int i = 12; i < 16; i++) load(i[3:0], 32'd0);
        1, 2, 3, 4: load(4'($urandom), coef_val());
        5: load(4'd15, 32'h0001_0000);
        default: xform(point_val(), point_val(), point_val());
      endcase
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d items sent, %0d points projected", n_items, n_points);
    $display("%0d with zero w, %0d clamped", n_wzero, n_clamped);
    if (fail_count == 0) begin
      $display("vertex_transform_perspective_divide verification clean");
    end else begin
      $display("vertex_transform_perspective_divide verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/vtp_pkg.sv
rtl/core/vtp_front.sv
rtl/core/vtp_queue.sv
rtl/core/vtp_divider.sv
rtl/core/vtp_back.sv
rtl/core/vertex_transform_perspective_divide.sv
tb/sv/vertex_transform_perspective_divide_checker.sv
tb/sv/vertex_transform_perspective_divide_tb.sv
